// ----- rtl/core/ecp_pkg.sv -----
// ecp_pkg: widths, types and helper functions of the edge crossing point pipeline
// no dependencies; used by the interfaces, the divider and the top level

package ecp_pkg;

    // coordinate format, signed fixed point
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // derived widths
    localparam int DW = COORD_WIDTH + 1;  // difference of two coordinates
    localparam int PW = 2 * DW;           // product of two differences
    localparam int SW = PW + 1;           // sum or difference of two products
    localparam int NW = SW + 1;           // denominator and magnitudes
    localparam int RW = NW + 1;           // shifted partial remainder
    localparam int KW = FRAC_BITS + 1;    // crossing fraction, 0 .. 1.0 inclusive
    localparam int LW = DW + KW + 1;      // edge offset product

    localparam logic [KW-1:0] K_ONE = KW'(1) << FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DW-1:0]          t_diff;
    typedef logic signed [PW-1:0]          t_prod;
    typedef logic signed [SW-1:0]          t_sum;
    typedef logic signed [NW-1:0]          t_den;
    typedef logic        [NW-1:0]          t_mag;
    typedef logic        [KW-1:0]          t_frac;
    typedef logic        [FRAC_BITS-1:0]   t_quot;
    typedef logic signed [LW-1:0]          t_off;

    // everything an item carries down the pipeline beside its working values
    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord sz;
        t_coord ex;
        t_coord ey;
        t_coord ez;
        t_coord cx;
        t_coord cz;
        t_coord tx;
        t_coord ty;
        t_coord tz;
        t_diff  dx;
        t_diff  dz;
        t_diff  gx;
        t_diff  gy;
        t_diff  gz;
        logic   zero_move;
        logic   to_start;
        logic   parallel;
        logic   kzero;
        logic   kfull;
    } t_ctx;

    // exact difference of two coordinates
    function automatic t_diff f_diff(t_coord a, t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    // exact product of two differences
    function automatic t_prod f_mul(t_diff a, t_diff b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    // magnitude of a signed denominator-width value
    function automatic t_mag f_mag(t_den a);
        return a[NW-1] ? t_mag'(-a) : t_mag'(a);
    endfunction

    // edge offset scaled by the fraction
    function automatic t_off f_scale(t_diff g, t_frac k);
        return t_off'(g) * t_off'(signed'({1'b0, k}));
    endfunction

endpackage

// ----- rtl/core/ecp_in_if.sv -----
// ecp_in_if: input channel carrying one edge query word
// depends on ecp_pkg for the coordinate type

interface ecp_in_if import ecp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord edge_start_x;
    t_coord edge_start_y;
    t_coord edge_start_z;
    t_coord edge_end_x;
    t_coord edge_end_y;
    t_coord edge_end_z;
    t_coord cur_x;
    t_coord cur_z;
    t_coord target_x;
    t_coord target_y;
    t_coord target_z;

    modport source (
        output valid, edge_start_x, edge_start_y, edge_start_z,
               edge_end_x, edge_end_y, edge_end_z, cur_x, cur_z,
               target_x, target_y, target_z,
        input  ready
    );

    modport sink (
        input  valid, edge_start_x, edge_start_y, edge_start_z,
               edge_end_x, edge_end_y, edge_end_z, cur_x, cur_z,
               target_x, target_y, target_z,
        output ready
    );
endinterface

// ----- rtl/core/ecp_out_if.sv -----
// ecp_out_if: output channel carrying one crossing point word
// depends on ecp_pkg for the coordinate type

interface ecp_out_if import ecp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    logic   crossed;

    modport source (
        output valid, point_x, point_y, point_z, crossed,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, crossed,
        output ready
    );
endinterface

// ----- rtl/core/ecp_div.sv -----
// ecp_div: pipelined restoring divider, one quotient bit per stage
// depends on ecp_pkg; gives floor(num * 2^FRAC_BITS / dv) for num < dv

module ecp_div import ecp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_mag  i_num,
    input  t_mag  i_dv,
    input  t_ctx  i_ctx,
    output logic  o_vld,
    output t_quot o_q,
    output t_ctx  o_ctx
);

    logic  r_vld [FRAC_BITS];
    t_mag  r_rem [FRAC_BITS];
    t_mag  r_dv  [FRAC_BITS];
    t_quot r_q   [FRAC_BITS];
    t_ctx  r_ctx [FRAC_BITS];

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_step
        logic          w_vld;
        t_mag          w_rem;
        t_mag          w_dv;
        t_quot         w_q;
        t_ctx          w_ctx;
        logic [RW-1:0] w_sh;
        logic [RW:0]   w_sub;
        logic          w_fit;

        // stage input: from the ports or the previous step
        if (s == 0) begin : g_first
            assign w_vld = i_vld;
            assign w_rem = i_num;
            assign w_dv  = i_dv;
            assign w_q   = '0;
            assign w_ctx = i_ctx;
        end else begin : g_next
            assign w_vld = r_vld[s-1];
            assign w_rem = r_rem[s-1];
            assign w_dv  = r_dv[s-1];
            assign w_q   = r_q[s-1];
            assign w_ctx = r_ctx[s-1];
        end

        // shift, trial subtract, keep on no borrow
        assign w_sh  = {w_rem, 1'b0};
        assign w_sub = {1'b0, w_sh} - {2'b00, w_dv};
        assign w_fit = !w_sub[RW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_fit ? w_sub[NW-1:0] : w_sh[NW-1:0];
                r_dv[s]  <= w_dv;
                r_q[s]   <= {w_q[FRAC_BITS-2:0], w_fit};
                r_ctx[s] <= w_ctx;
            end
        end
    end

    assign o_vld = r_vld[FRAC_BITS-1];
    assign o_q   = r_q[FRAC_BITS-1];
    assign o_ctx = r_ctx[FRAC_BITS-1];

endmodule

// ----- rtl/core/edge_crossing_point_2d.sv -----
// edge_crossing_point_2d: top level of the edge crossing point pipeline
// depends on ecp_pkg, ecp_in_if, ecp_out_if and ecp_div

// The block takes one query word per cycle and returns one point word per query, in
// order: six stages form the differences, cross products and magnitudes, a
// sixteen-stage divider yields one fraction bit per stage, and six more stages
// interpolate the point, test which side of the mover it lies on and pick the result
// into the output register. Every stage advances together; while a finished word
// waits in the output register and the sink is not ready, the whole pipeline holds
// and no new word is taken.

module edge_crossing_point_2d import ecp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ecp_in_if.sink       i_in,
    ecp_out_if.source    o_out
);

    logic w_en;

    // stage registers
    logic  r_st1_vld, r_st2_vld, r_st3_vld, r_st4_vld, r_st5_vld, r_st6_vld;
    logic  r_st7_vld, r_st8_vld, r_st9_vld, r_st10_vld, r_st11_vld, r_out_vld;
    t_ctx  r_st1_ctx, r_st2_ctx, r_st3_ctx, r_st4_ctx, r_st5_ctx, r_st6_ctx;
    t_ctx  r_st7_ctx, r_st8_ctx, r_st9_ctx, r_st10_ctx, r_st11_ctx;
    t_diff r_st1_asx, r_st1_asz, r_st1_aex, r_st1_aez;
    t_prod r_st2_p1, r_st2_p2, r_st2_p3, r_st2_p4, r_st2_p5, r_st2_p6;
    t_sum  r_st3_ds, r_st3_de;
    t_den  r_st4_den;
    t_mag  r_st4_num, r_st5_num, r_st6_num;
    logic  r_st4_ds_zero, r_st4_ds_neg;
    t_mag  r_st5_dv, r_st6_dv;
    t_frac r_st7_k;
    t_off  r_st8_ox, r_st8_oy, r_st8_oz;
    t_coord r_st9_px, r_st9_py, r_st9_pz;
    t_coord r_st10_px, r_st10_py, r_st10_pz;
    t_coord r_st11_px, r_st11_py, r_st11_pz;
    t_diff r_st10_ax, r_st10_az;
    t_prod r_st11_mx, r_st11_mz;
    t_coord r_out_x, r_out_y, r_out_z;
    logic  r_out_crossed;

    // divider outputs
    logic  w_div_vld;
    t_quot w_div_q;
    t_ctx  w_div_ctx;

    // next values
    t_ctx   n_st1_ctx, n_st3_ctx, n_st5_ctx, n_st6_ctx, n_st7_ctx;
    t_frac  n_k;
    t_sum   n_side;
    t_coord n_x, n_y, n_z;
    logic   n_crossed;

    // sign of the edge dot move
    function automatic logic n_st3_to_start(t_prod a, t_prod b);
        t_sum dot;
        dot = t_sum'(a) + t_sum'(b);
        return dot[SW-1];
    endfunction

    // the pipeline moves as one while the output register can take a word
    assign w_en        = !r_out_vld || o_out.ready;
    assign i_in.ready  = w_en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1_vld  <= 1'b0;
            r_st2_vld  <= 1'b0;
            r_st3_vld  <= 1'b0;
            r_st4_vld  <= 1'b0;
            r_st5_vld  <= 1'b0;
            r_st6_vld  <= 1'b0;
            r_st7_vld  <= 1'b0;
            r_st8_vld  <= 1'b0;
            r_st9_vld  <= 1'b0;
            r_st10_vld <= 1'b0;
            r_st11_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (w_en) begin
            r_st1_vld  <= i_in.valid;
            r_st2_vld  <= r_st1_vld;
            r_st3_vld  <= r_st2_vld;
            r_st4_vld  <= r_st3_vld;
            r_st5_vld  <= r_st4_vld;
            r_st6_vld  <= r_st5_vld;
            r_st7_vld  <= w_div_vld;
            r_st8_vld  <= r_st7_vld;
            r_st9_vld  <= r_st8_vld;
            r_st10_vld <= r_st9_vld;
            r_st11_vld <= r_st10_vld;
            r_out_vld  <= r_st11_vld;
        end
    end

    // stage 1: capture the word, move and edge directions
    always_comb begin
        n_st1_ctx           = '0;
        n_st1_ctx.sx        = i_in.edge_start_x;
        n_st1_ctx.sy        = i_in.edge_start_y;
        n_st1_ctx.sz        = i_in.edge_start_z;
        n_st1_ctx.ex        = i_in.edge_end_x;
        n_st1_ctx.ey        = i_in.edge_end_y;
        n_st1_ctx.ez        = i_in.edge_end_z;
        n_st1_ctx.cx        = i_in.cur_x;
        n_st1_ctx.cz        = i_in.cur_z;
        n_st1_ctx.tx        = i_in.target_x;
        n_st1_ctx.ty        = i_in.target_y;
        n_st1_ctx.tz        = i_in.target_z;
        n_st1_ctx.dx        = f_diff(i_in.target_x, i_in.cur_x);
        n_st1_ctx.dz        = f_diff(i_in.target_z, i_in.cur_z);
        n_st1_ctx.gx        = f_diff(i_in.edge_end_x, i_in.edge_start_x);
        n_st1_ctx.gy        = f_diff(i_in.edge_end_y, i_in.edge_start_y);
        n_st1_ctx.gz        = f_diff(i_in.edge_end_z, i_in.edge_start_z);
        n_st1_ctx.zero_move = (i_in.target_x == i_in.cur_x) && (i_in.target_z == i_in.cur_z);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st1_ctx <= n_st1_ctx;
            r_st1_asx <= f_diff(i_in.edge_start_x, i_in.cur_x);
            r_st1_asz <= f_diff(i_in.edge_start_z, i_in.cur_z);
            r_st1_aex <= f_diff(i_in.edge_end_x, i_in.cur_x);
            r_st1_aez <= f_diff(i_in.edge_end_z, i_in.cur_z);
        end
    end

    // stage 2: cross and dot products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st2_ctx <= r_st1_ctx;
            r_st2_p1  <= f_mul(r_st1_ctx.dz, r_st1_asx);
            r_st2_p2  <= f_mul(r_st1_ctx.dx, r_st1_asz);
            r_st2_p3  <= f_mul(r_st1_ctx.dz, r_st1_aex);
            r_st2_p4  <= f_mul(r_st1_ctx.dx, r_st1_aez);
            r_st2_p5  <= f_mul(r_st1_ctx.gz, r_st1_ctx.dz);
            r_st2_p6  <= f_mul(r_st1_ctx.gx, r_st1_ctx.dx);
        end
    end

    // stage 3: side distances of both endpoints, snap direction
    always_comb begin
        n_st3_ctx          = r_st2_ctx;
        n_st3_ctx.to_start = n_st3_to_start(r_st2_p5, r_st2_p6);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st3_ctx <= n_st3_ctx;
            r_st3_ds  <= t_sum'(r_st2_p1) - t_sum'(r_st2_p2);
            r_st3_de  <= t_sum'(r_st2_p3) - t_sum'(r_st2_p4);
        end
    end

    // stage 4: denominator and numerator magnitude
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st4_ctx     <= r_st3_ctx;
            r_st4_den     <= t_den'(r_st3_ds) - t_den'(r_st3_de);
            r_st4_num     <= f_mag(t_den'(r_st3_ds));
            r_st4_ds_zero <= (r_st3_ds == '0);
            r_st4_ds_neg  <= r_st3_ds[SW-1];
        end
    end

    // stage 5: parallel test, zero fraction test, divisor magnitude
    always_comb begin
        n_st5_ctx          = r_st4_ctx;
        n_st5_ctx.parallel = (r_st4_den == '0);
        n_st5_ctx.kzero    = r_st4_ds_zero || (r_st4_ds_neg != r_st4_den[NW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st5_ctx <= n_st5_ctx;
            r_st5_num <= r_st4_num;
            r_st5_dv  <= f_mag(r_st4_den);
        end
    end

    // stage 6: full fraction when the numerator reaches the divisor
    always_comb begin
        n_st6_ctx       = r_st5_ctx;
        n_st6_ctx.kfull = (r_st5_num >= r_st5_dv);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st6_ctx <= n_st6_ctx;
            r_st6_num <= r_st5_num;
            r_st6_dv  <= r_st5_dv;
        end
    end

    // fraction bits
    ecp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_st6_vld),
        .i_num   (r_st6_num),
        .i_dv    (r_st6_dv),
        .i_ctx   (r_st6_ctx),
        .o_vld   (w_div_vld),
        .o_q     (w_div_q),
        .o_ctx   (w_div_ctx)
    );

    // stage 7: clamp the fraction
    always_comb begin
        n_st7_ctx = w_div_ctx;
        if (w_div_ctx.kzero) begin
            n_k = '0;
        end else if (w_div_ctx.kfull) begin
            n_k = K_ONE;
        end else begin
            n_k = {1'b0, w_div_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st7_ctx <= n_st7_ctx;
            r_st7_k   <= n_k;
        end
    end

    // stage 8: scaled edge offsets
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st8_ctx <= r_st7_ctx;
            r_st8_ox  <= f_scale(r_st7_ctx.gx, r_st7_k);
            r_st8_oy  <= f_scale(r_st7_ctx.gy, r_st7_k);
            r_st8_oz  <= f_scale(r_st7_ctx.gz, r_st7_k);
        end
    end

    // stage 9: interpolated point, floor of the offset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st9_ctx <= r_st8_ctx;
            r_st9_px  <= r_st8_ctx.sx + t_coord'(r_st8_ox[FRAC_BITS +: COORD_WIDTH]);
            r_st9_py  <= r_st8_ctx.sy + t_coord'(r_st8_oy[FRAC_BITS +: COORD_WIDTH]);
            r_st9_pz  <= r_st8_ctx.sz + t_coord'(r_st8_oz[FRAC_BITS +: COORD_WIDTH]);
        end
    end

    // stage 10: point relative to the mover
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st10_ctx <= r_st9_ctx;
            r_st10_px  <= r_st9_px;
            r_st10_py  <= r_st9_py;
            r_st10_pz  <= r_st9_pz;
            r_st10_ax  <= f_diff(r_st9_px, r_st9_ctx.cx);
            r_st10_az  <= f_diff(r_st9_pz, r_st9_ctx.cz);
        end
    end

    // stage 11: terms of the side test
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st11_ctx <= r_st10_ctx;
            r_st11_px  <= r_st10_px;
            r_st11_py  <= r_st10_py;
            r_st11_pz  <= r_st10_pz;
            r_st11_mx  <= f_mul(r_st10_ctx.dx, r_st10_ax);
            r_st11_mz  <= f_mul(r_st10_ctx.dz, r_st10_az);
        end
    end

    // result select: target, snapped endpoint or crossing point
    always_comb begin
        n_side    = t_sum'(r_st11_mx) + t_sum'(r_st11_mz);
        n_crossed = 1'b0;
        if (r_st11_ctx.zero_move) begin
            n_x = r_st11_ctx.tx;
            n_y = r_st11_ctx.ty;
            n_z = r_st11_ctx.tz;
        end else if (r_st11_ctx.parallel || n_side[SW-1]) begin
            n_crossed = !r_st11_ctx.parallel;
            if (r_st11_ctx.to_start) begin
                n_x = r_st11_ctx.sx;
                n_y = r_st11_ctx.sy;
                n_z = r_st11_ctx.sz;
            end else begin
                n_x = r_st11_ctx.ex;
                n_y = r_st11_ctx.ey;
                n_z = r_st11_ctx.ez;
            end
        end else begin
            n_crossed = 1'b1;
            n_x       = r_st11_px;
            n_y       = r_st11_py;
            n_z       = r_st11_pz;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x       <= n_x;
            r_out_y       <= n_y;
            r_out_z       <= n_z;
            r_out_crossed <= n_crossed;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.point_x = r_out_x;
    assign o_out.point_y = r_out_y;
    assign o_out.point_z = r_out_z;
    assign o_out.crossed = r_out_crossed;

endmodule
